// ----- rtl/static_route_first_match_lookup_unit_assert.svh -----
// Assertion macros used by the lookup controller.
`ifndef STATIC_ROUTE_FIRST_MATCH_LOOKUP_UNIT_ASSERT_SVH
`define STATIC_ROUTE_FIRST_MATCH_LOOKUP_UNIT_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define SRFML_ASSERT(name, clk, rstn, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checks that a condition never holds outside reset.
`define SRFML_NEVER(name, clk, rstn, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/srfml_pkg.sv -----
// Package with the beat types, table entry type and control structs of the lookup unit.
`timescale 1ns / 1ps

package srfml_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;

	localparam logic MODE_ADD    = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef struct packed {
		logic        mode;
		logic [3:0]  slot;
		logic [31:0] net_address;
		logic [31:0] net_mask;
		logic [31:0] gateway_address;
		logic        via_gateway_in;
		logic [3:0]  port_in;
		logic [31:0] dest_address;
		logic        arp_reply;
	} item_t;

	typedef struct packed {
		logic        matched;
		logic [31:0] next_hop;
		logic [3:0]  port_out;
		logic        via_gateway;
		logic        send_arp;
	} result_t;

	typedef struct packed {
		logic [31:0] net;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic        via_gateway;
		logic [3:0]  port;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_entry;
		logic load_dest;
		logic issue;
		logic finish_hit;
		logic finish_none;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic dest_zero;
		logic more;
		logic hit;
		logic stop;
	} sts_t;

endpackage

// ----- rtl/srfml_dpath.sv -----
// Datapath of the lookup unit: table memory, entry count, walk index and result register.
`timescale 1ns / 1ps

module srfml_dpath #(
	parameter int TABLE_DEPTH = srfml_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srfml_pkg::item_t  item,
	input  srfml_pkg::cmd_t   cmd,
	output srfml_pkg::sts_t   sts,
	output srfml_pkg::result_t result
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	srfml_pkg::entry_t mem [TABLE_DEPTH];
	srfml_pkg::entry_t rd_s1;
	srfml_pkg::entry_t wr_entry;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  idx_q;
	logic [31:0]       dest_q;
	logic              arp_q;
	logic [31:0]       masked;
	logic              slot_ok;
	srfml_pkg::result_t res_d;
	srfml_pkg::result_t res_q;

	assign slot_ok = 32'(item.slot) < 32'(TABLE_DEPTH);

	always_comb begin
		wr_entry.net         = item.net_address;
		wr_entry.mask        = item.net_mask;
		wr_entry.gateway     = item.gateway_address;
		wr_entry.via_gateway = item.via_gateway_in;
		wr_entry.port        = item.port_in;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_entry && slot_ok) begin
			mem[IDX_W'(item.slot)] <= wr_entry;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[idx_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.wr_entry && (count_q != CNT_W'(TABLE_DEPTH))) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_dest) begin
				idx_q <= '0;
			end else if (cmd.issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dest) begin
			dest_q <= item.dest_address;
			arp_q  <= item.arp_reply;
		end
	end

	assign masked = dest_q & rd_s1.mask;

	always_comb begin
		sts.dest_zero = (dest_q[31:24] == 8'd0);
		sts.more      = idx_q < count_q;
		sts.stop      = (masked[31:24] == 8'd0);
		sts.hit       = (masked == rd_s1.net);
	end

	// A miss leaves every field at zero; an ARP-reply hit reports only the match.
	always_comb begin
		res_d = '0;
		if (cmd.finish_hit) begin
			res_d.matched = 1'b1;
			if (!arp_q) begin
				res_d.next_hop    = rd_s1.via_gateway ? rd_s1.gateway : dest_q;
				res_d.port_out    = rd_s1.port;
				res_d.via_gateway = rd_s1.via_gateway;
				res_d.send_arp    = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_none || cmd.finish_hit) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

// ----- rtl/srfml_ctrl.sv -----
// Controller state machine that sequences table writes and the lookup walk.
`timescale 1ns / 1ps
`include "static_route_first_match_lookup_unit_assert.svh"

module srfml_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            mode,
	input  srfml_pkg::sts_t sts,
	output srfml_pkg::cmd_t cmd,
	output logic            busy,
	output logic            done
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   done_q;
	logic   accept;
	logic   finish;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == srfml_pkg::MODE_LOOKUP) begin
						cmd.load_dest = 1'b1;
						state_d       = ST_WALK;
					end else begin
						cmd.wr_entry = 1'b1;
					end
				end
			end
			ST_WALK: begin
				// A zero first destination octet ends the walk before the compare counts.
				if (sts.dest_zero) begin
					cmd.finish_none = 1'b1;
				end else if (pend_q && sts.stop) begin
					cmd.finish_none = 1'b1;
				end else if (pend_q && sts.hit) begin
					cmd.finish_hit = 1'b1;
				end else if (!sts.more) begin
					cmd.finish_none = 1'b1;
				end else begin
					cmd.issue = 1'b1;
				end
				if (cmd.finish_none || cmd.finish_hit) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign finish = cmd.finish_none || cmd.finish_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= cmd.issue;
			done_q  <= finish;
		end
	end

	`SRFML_ASSERT(a_done_after_walk, clk, arst_n, done_q |-> ($past(state_q) == ST_WALK), "result strobe without a walk")
	`SRFML_ASSERT(a_issue_in_range, clk, arst_n, cmd.issue |-> sts.more, "entry read past the entry count")
	`SRFML_ASSERT(a_hit_needs_data, clk, arst_n, cmd.finish_hit |-> pend_q, "match taken without read data")
	`SRFML_ASSERT(a_lookup_enters_walk, clk, arst_n, (accept && mode) |=> (state_q == ST_WALK), "lookup did not start a walk")
	`SRFML_NEVER(a_write_while_busy, clk, arst_n, cmd.wr_entry && busy, "table written during a walk")

endmodule

// ----- rtl/static_route_first_match_lookup_unit.sv -----
// Top level of the static route first-match lookup unit.
`timescale 1ns / 1ps
// An add beat is written at its accept edge, keeps busy low and gives no result.
// A lookup loads the destination, reads each entry into the registered table read and
// compares it; done is registered after the deciding entry or a zero first destination octet.
// Throughput: one entry per cycle through the registered table read; a new beat is taken
// in the cycle that done is high. The receiver cannot stall. Reset clears the entry count.

module static_route_first_match_lookup_unit #(
	parameter int TABLE_DEPTH = srfml_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  srfml_pkg::item_t   item,
	output logic               busy,
	output logic               done,
	output srfml_pkg::result_t result
);

	// Commands and status between the controller and the datapath.
	srfml_pkg::cmd_t cmd;
	srfml_pkg::sts_t sts;

	// The controller decodes accepted beats and steps the walk one entry per cycle.
	srfml_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the table memory, the entry count and the result register.
	// The table contents are not cleared by reset; only entries below the count are read.
	srfml_dpath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
